FILE: design/rthsv_pkg.sv
package rthsv_pkg;

    // channel and arithmetic widths
    localparam int CH_W        = 8;
    localparam int COLOUR_W    = 3 * CH_W;
    localparam int K_W         = 11;
    localparam int NUM_W       = 24;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int QUO_W       = 17;
    localparam int HUE_W       = 16;
    localparam int SAT_W       = 17;
    localparam int SAT_SHIFT   = 16;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;

    // 65280 / 6: one sixth of the hue circle in 8.8 units
    localparam int                HUE_SCALE_W = 14;
    localparam logic [HUE_SCALE_W-1:0] HUE_SCALE = 14'd10880;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // one classified request handed from front to back
    typedef struct packed {
        logic [NUM_W-1:0] hue_num;
        logic [CH_W-1:0]  hue_den;
        logic [CH_W-1:0]  sat_range;
        logic [CH_W-1:0]  value;
    } job_t;

endpackage

FILE: design/rthsv_front.sv
module rthsv_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rthsv_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                                job_valid,
    input  logic                                job_ready,
    output rthsv_pkg::job_t                     job
);

    localparam int CH_W  = rthsv_pkg::CH_W;
    localparam int K_W   = rthsv_pkg::K_W;
    localparam int PRD_W = K_W + rthsv_pkg::HUE_SCALE_W;

    logic [CH_W-1:0] red, green, blue;
    logic [CH_W-1:0] max_c, min_c, range_c;
    logic            red_max, green_max;
    logic [K_W-1:0]  k_c;
    logic            front_en;

    logic            f1_valid_reg;
    logic [K_W-1:0]  k_reg;
    logic [CH_W-1:0] hue_den_reg;
    logic [CH_W-1:0] range_reg;
    logic [CH_W-1:0] value_reg;

    logic            f2_valid_reg;
    rthsv_pkg::job_t job_reg;
    logic [PRD_W-1:0] hue_prod;

    assign red   = s_tdata[CH_W-1:0];
    assign green = s_tdata[2*CH_W-1:CH_W];
    assign blue  = s_tdata[3*CH_W-1:2*CH_W];

    always_comb
    begin
        max_c = red;
        min_c = red;
        if (green > max_c)
        begin
            max_c = green;
        end
        if (blue > max_c)
        begin
            max_c = blue;
        end
        if (green < min_c)
        begin
            min_c = green;
        end
        if (blue < min_c)
        begin
            min_c = blue;
        end
        range_c = max_c - min_c;
    end

    // ties: red over green, green over blue
    assign red_max   = (red >= green) && (red >= blue);
    assign green_max = !red_max && (green >= blue);

    // sector offset plus signed channel difference, never negative in total
    always_comb
    begin
        if (range_c == '0)
        begin
            k_c = '0;
        end
        else if (red_max)
        begin
            if (green >= blue)
            begin
                k_c = K_W'(green - blue);
            end
            else
            begin
                k_c = K_W'(6 * range_c) - K_W'(blue - green);
            end
        end
        else if (green_max)
        begin
            k_c = K_W'({range_c, 1'b0}) + K_W'(blue) - K_W'(red);
        end
        else
        begin
            k_c = K_W'({range_c, 2'b00}) + K_W'(red) - K_W'(green);
        end
    end

    // stall both stages only when the last one cannot hand over
    assign front_en  = !f2_valid_reg || job_ready;
    assign s_tready  = front_en;
    assign job_valid = f2_valid_reg;
    assign job       = job_reg;

    assign hue_prod = k_reg * rthsv_pkg::HUE_SCALE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (front_en)
        begin
            f1_valid_reg <= s_tvalid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_en)
        begin
            k_reg             <= k_c;
            hue_den_reg       <= (range_c == '0) ? CH_W'(1) : range_c;
            range_reg         <= range_c;
            value_reg         <= max_c;
            job_reg.hue_num   <= hue_prod[rthsv_pkg::NUM_W-1:0];
            job_reg.hue_den   <= hue_den_reg;
            job_reg.sat_range <= range_reg;
            job_reg.value     <= value_reg;
        end
    end

endmodule

FILE: design/rthsv_queue.sv
module rthsv_queue #(
    parameter int DEPTH = rthsv_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  rthsv_pkg::job_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output rthsv_pkg::job_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    rthsv_pkg::job_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/rthsv_back.sv
module rthsv_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                job_valid,
    output logic                                job_ready,
    input  rthsv_pkg::job_t                     job,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rthsv_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    localparam int CH_W    = rthsv_pkg::CH_W;
    localparam int NUM_W   = rthsv_pkg::NUM_W;
    localparam int RECIP_W = rthsv_pkg::RECIP_W;
    localparam int QUO_W   = rthsv_pkg::QUO_W;
    localparam int HUE_W   = rthsv_pkg::HUE_W;
    localparam int SAT_W   = rthsv_pkg::SAT_W;
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam int BACK_W  = QUO_W + CH_W;
    localparam int LANES   = 2;
    localparam int TAB_N   = 1 << CH_W;
    localparam int PAD_W   = rthsv_pkg::OUT_TDATA_W - HUE_W - SAT_W - CH_W;

    // lane 0 carries hue, lane 1 saturation
    localparam int HUE_L = 0;
    localparam int SAT_L = 1;

    logic [RECIP_W-1:0] recip_tab [TAB_N];

    // floor(2^24 / d), built at elaboration
    for (genvar i = 0; i < TAB_N; i++)
    begin : g_recip
        localparam logic [RECIP_W-1:0] RC =
            RECIP_W'((1 << rthsv_pkg::RECIP_SHIFT) / ((i == 0) ? 1 : i));
        assign recip_tab[i] = RC;
    end

    logic                back_en;
    logic [NUM_W-1:0]    num_c  [LANES];
    logic [CH_W-1:0]     den_c  [LANES];
    logic [PROD_W-1:0]   prod_c [LANES];

    logic                b1_valid_reg;
    logic [QUO_W-1:0]    b1_q0_reg  [LANES];
    logic [NUM_W-1:0]    b1_num_reg [LANES];
    logic [CH_W-1:0]     b1_den_reg [LANES];
    logic [CH_W-1:0]     b1_value_reg;

    logic [BACK_W-1:0]   back_c [LANES];

    logic                b2_valid_reg;
    logic [QUO_W-1:0]    b2_q0_reg   [LANES];
    logic [NUM_W-1:0]    b2_num_reg  [LANES];
    logic [CH_W-1:0]     b2_den_reg  [LANES];
    logic [BACK_W-1:0]   b2_back_reg [LANES];
    logic [CH_W-1:0]     b2_value_reg;

    logic [NUM_W:0]      rem_c [LANES];
    logic [QUO_W-1:0]    quo_c [LANES];

    logic                out_valid_reg;
    logic [HUE_W-1:0]    hue_reg;
    logic [SAT_W-1:0]    sat_reg;
    logic [CH_W-1:0]     value_reg;

    assign back_en   = !out_valid_reg || m_tready;
    assign job_ready = back_en;

    always_comb
    begin
        num_c[HUE_L] = job.hue_num;
        den_c[HUE_L] = job.hue_den;
        num_c[SAT_L] = {job.sat_range, {rthsv_pkg::SAT_SHIFT{1'b0}}};
        den_c[SAT_L] = (job.value == '0) ? CH_W'(1) : job.value;
        for (int l = 0; l < LANES; l++)
        begin
            prod_c[l] = num_c[l] * recip_tab[den_c[l]];
            back_c[l] = b1_q0_reg[l] * b1_den_reg[l];
            rem_c[l]  = {1'b0, b2_num_reg[l]} - (NUM_W + 1)'(b2_back_reg[l]);
            quo_c[l]  = (rem_c[l] >= (NUM_W + 1)'(b2_den_reg[l]))
                        ? b2_q0_reg[l] + QUO_W'(1) : b2_q0_reg[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (back_en)
        begin
            b1_valid_reg  <= job_valid;
            b2_valid_reg  <= b1_valid_reg;
            out_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                b1_q0_reg[l]   <= prod_c[l][rthsv_pkg::RECIP_SHIFT +: QUO_W];
                b1_num_reg[l]  <= num_c[l];
                b1_den_reg[l]  <= den_c[l];
                b2_q0_reg[l]   <= b1_q0_reg[l];
                b2_num_reg[l]  <= b1_num_reg[l];
                b2_den_reg[l]  <= b1_den_reg[l];
                b2_back_reg[l] <= back_c[l];
            end
            b1_value_reg <= job.value;
            b2_value_reg <= b1_value_reg;
            hue_reg      <= quo_c[HUE_L][HUE_W-1:0];
            sat_reg      <= quo_c[SAT_L][SAT_W-1:0];
            value_reg    <= b2_value_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, value_reg, sat_reg, hue_reg};

endmodule

FILE: design/rgb_to_hsv_colour.sv
// Channel  Dir  Group       tdata fields (lowest bit first)
// s_       in   s_tvalid/s_tready  colour[23:0]: red 7:0, green 15:8, blue 23:16
// m_       out  m_tvalid/m_tready  hue_fixed[15:0], saturation_frac[32:16],
//                                  value_level[40:33], zero fill [47:41]
//
// One request is taken per clock while s_tready is high. A result passes through
// the two front stages (min/max classify, hue numerator multiply), the queue,
// and the three back stages of the reciprocal divider (table multiply, back
// multiply, correct).
// rst_n clears all valid flags and queue pointers at once; data needs no reset.
// A stall on m_tready holds the back; the front keeps accepting until the
// queue fills, then s_tready drops.
module rgb_to_hsv_colour #(
    parameter int QUEUE_DEPTH = rthsv_pkg::QUEUE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // colour: red 7:0, green 15:8, blue 23:16
    input  logic [rthsv_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // hue_fixed 15:0, saturation_frac 32:16, value_level 40:33, zero 47:41
    output logic [rthsv_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    // classified request leaving the front
    logic            front_valid;
    logic            front_ready;
    rthsv_pkg::job_t front_job;

    // request waiting at the head of the queue
    logic            back_valid;
    logic            back_ready;
    rthsv_pkg::job_t back_job;

    // Front: find max/min, pick the sector, build the hue numerator.
    rthsv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    // Queue: decouple the front from output back-pressure.
    rthsv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_job)
    );

    // Back: divide hue and saturation numerators by reciprocal multiply,
    // then correct the quotient by one where the remainder allows.
    rthsv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .job       (back_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
